// ===== hw/rtl/npcs_pkg.sv =====
// Shared types and constants for the nearest palette color search block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package npcs_pkg;

	// Field widths fixed by the port list
	localparam int unsigned CH_W     = 8;
	localparam int unsigned IDX_W    = 8;
	localparam int unsigned SQ_W     = 2 * CH_W;
	localparam int unsigned DIST_W   = 18;

	// Default palette depth
	localparam int unsigned PALETTE_ENTRIES_DEF = 256;

	// One palette color
	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} rgb_t;

	// Control fanned out to every cell of the chain
	typedef struct packed {
		logic             shift;
		logic             wr;
		logic [IDX_W-1:0] wr_index;
		rgb_t             wr_data;
	} cell_ctl_t;

	// Side info that travels with each distance beat
	typedef struct packed {
		logic             first;
		logic             last;
		logic [IDX_W-1:0] idx;
	} dist_tag_t;

endpackage : npcs_pkg

`default_nettype wire

// ===== hw/rtl/npcs_cell.sv =====
// One palette cell: holds a single entry, loads it on a matching write,
// and takes its neighbor's entry on every rotate cycle. Uses npcs_pkg.
`default_nettype none

module npcs_cell
	import npcs_pkg::*;
#(
	parameter int unsigned CELL_IDX = 0
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_ctl_t ctl,
	input  wire rgb_t      nbr,
	output rgb_t           entry
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	rgb_t entry_q;
	logic hit;

	// Address decode for this cell
	assign hit = ctl.wr && (ctl.wr_index == MY_IDX);

	// Entry register, black after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (ctl.shift) begin
			entry_q <= nbr;
		end else if (hit) begin
			entry_q <= ctl.wr_data;
		end
	end

	assign entry = entry_q;

endmodule : npcs_cell

`default_nettype wire

// ===== hw/rtl/npcs_dist.sv =====
// Two-stage squared RGB distance unit fed from the head of the cell chain.
// Stage 1 squares the channel differences, stage 2 sums them. Uses npcs_pkg.
`default_nettype none

module npcs_dist
	import npcs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire dist_tag_t in_tag,
	input  wire rgb_t      entry,
	input  wire rgb_t      query,
	output logic           out_valid,
	output dist_tag_t      out_tag,
	output logic [DIST_W-1:0] sq_dist
);

	logic [CH_W-1:0] dr, dg, db;
	logic            v_s1, v_s2;
	dist_tag_t       tag_s1, tag_s2;
	logic [SQ_W-1:0] sqr_s1, sqg_s1, sqb_s1;
	logic [DIST_W-1:0] sum_s2;

	// Absolute channel differences
	assign dr = (entry.r > query.r) ? (entry.r - query.r) : (query.r - entry.r);
	assign dg = (entry.g > query.g) ? (entry.g - query.g) : (query.g - entry.g);
	assign db = (entry.b > query.b) ? (entry.b - query.b) : (query.b - entry.b);

	// Beat valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// Stage 1: squares; stage 2: sum
	always_ff @(posedge clk) begin
		tag_s1 <= in_tag;
		sqr_s1 <= SQ_W'(dr) * SQ_W'(dr);
		sqg_s1 <= SQ_W'(dg) * SQ_W'(dg);
		sqb_s1 <= SQ_W'(db) * SQ_W'(db);
		tag_s2 <= tag_s1;
		sum_s2 <= DIST_W'(sqr_s1) + DIST_W'(sqg_s1) + DIST_W'(sqb_s1);
	end

	assign out_valid = v_s2;
	assign out_tag   = tag_s2;
	assign sq_dist   = sum_s2;

endmodule : npcs_dist

`default_nettype wire

// ===== hw/rtl/nearest_palette_color_search_top.sv =====
// Nearest palette color search: a ring of palette cells rotates one entry
// per cycle past a single squared-distance unit. Uses npcs_pkg, npcs_cell, npcs_dist.
// Write: busy stays low, no result.
// Query: done pulses once the ring has turned and the pipeline has drained; busy drops with done,
//   so a new query is taken only after the last one is through (ring turn plus pipeline).
// Reset clears every palette entry to black and idles the controller; done is never held off.
`default_nettype none

module nearest_palette_color_search_top
	import npcs_pkg::*;
#(
	parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              func,
	input  wire logic [IDX_W-1:0]  entry_index,
	input  wire logic [CH_W-1:0]   red,
	input  wire logic [CH_W-1:0]   green,
	input  wire logic [CH_W-1:0]   blue,
	output logic                   done,
	output logic [IDX_W-1:0]       best_index,
	output logic [DIST_W-1:0]      best_distance
);

	localparam int unsigned CNT_W = $clog2(PALETTE_ENTRIES);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PALETTE_ENTRIES - 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	rgb_t             query_q;
	logic             accept, query_go;
	logic             issue, issue_last;
	cell_ctl_t        ctl;
	rgb_t             chain [PALETTE_ENTRIES];
	dist_tag_t        issue_tag, res_tag;
	logic             res_valid;
	logic [DIST_W-1:0] res_dist;
	logic             take;
	logic [IDX_W-1:0]  nxt_idx, best_idx_q, out_idx_q;
	logic [DIST_W-1:0] nxt_dist, lead_dist_q, out_dist_q;
	logic             done_q;

	// Input beat handshake
	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign query_go = accept && func;

	// Scan issue: one entry from the chain head per cycle
	assign issue      = (state_q == ST_SCAN);
	assign issue_last = (cnt_q == CNT_LAST);
	assign issue_tag.first = (cnt_q == '0);
	assign issue_tag.last  = issue_last;
	assign issue_tag.idx   = IDX_W'(cnt_q);

	// Cell control
	assign ctl.shift    = issue;
	assign ctl.wr       = accept && !func;
	assign ctl.wr_index = entry_index;
	assign ctl.wr_data  = '{r: red, g: green, b: blue};

	// Ring of cells; cell k takes cell k+1, the last wraps to the head
	for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
		npcs_cell #(
			.CELL_IDX(k)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.nbr   (chain[(k + 1) % PALETTE_ENTRIES]),
			.entry (chain[k])
		);
	end

	// Distance unit at the chain head
	npcs_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (issue),
		.in_tag   (issue_tag),
		.entry    (chain[0]),
		.query    (query_q),
		.out_valid(res_valid),
		.out_tag  (res_tag),
		.sq_dist  (res_dist)
	);

	// Running best: strictly smaller wins, so ties keep the lowest index
	assign take     = res_tag.first || (res_dist < lead_dist_q);
	assign nxt_idx  = take ? res_tag.idx : best_idx_q;
	assign nxt_dist = take ? res_dist : lead_dist_q;

	// Controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= res_valid && res_tag.last;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (query_go) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (issue_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					cnt_q <= '0;
					if (res_valid && res_tag.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	// Query color, best tracking and result registers
	always_ff @(posedge clk) begin
		if (query_go) begin
			query_q <= '{r: red, g: green, b: blue};
		end
		if (res_valid) begin
			best_idx_q  <= nxt_idx;
			lead_dist_q <= nxt_dist;
			if (res_tag.last) begin
				out_idx_q  <= nxt_idx;
				out_dist_q <= nxt_dist;
			end
		end
	end

	assign done          = done_q;
	assign best_index    = out_idx_q;
	assign best_distance = out_dist_q;

endmodule : nearest_palette_color_search_top

`default_nettype wire

// ===== tb/nearest_palette_color_search_checker.sv =====
// Checker for the nearest palette color search block: keeps its own copy of the palette,
// works out each query's nearest entry and compares it with the done beat.
// Depends on npcs_pkg; also holds npcs_tb_pkg, the function codes shared with the tb top.
`timescale 1ns / 1ps

package npcs_tb_pkg;

	// Command codes on the func port
	typedef enum logic {
		FUNC_WRITE = 1'b0,
		FUNC_QUERY = 1'b1
	} func_e;

endpackage : npcs_tb_pkg

module nearest_palette_color_search_checker
	import npcs_pkg::*;
	import npcs_tb_pkg::*;
#(
	parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              busy,
	input  wire logic              func,
	input  wire logic [IDX_W-1:0]  entry_index,
	input  wire logic [CH_W-1:0]   red,
	input  wire logic [CH_W-1:0]   green,
	input  wire logic [CH_W-1:0]   blue,
	input  wire logic              done,
	input  wire logic [IDX_W-1:0]  best_index,
	input  wire logic [DIST_W-1:0] best_distance,
	output int                     fail_count,
	output int                     pending
);

	// Index and distance of one query answer
	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] dist_val;
	} match_t;

	rgb_t   palette_copy [256];
	match_t nearest_due [$];   // answers of accepted queries, oldest first
	int     errors = 0;

	function automatic int unsigned chan_sq(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
		int unsigned d;
		d = (a > b) ? a - b : b - a;
		return d * d;
	endfunction

	// Scan in index order; only a strictly smaller distance replaces, so ties keep the lowest
	function automatic match_t find_nearest(rgb_t q);
		match_t      best;
		int unsigned sq_sum;
		int unsigned lead_dist;
		lead_dist = 32'hFFFF_FFFF;
		best.idx  = '0;
		for (int i = 0; i < int'(PALETTE_ENTRIES) && i < 256; i++) begin
			sq_sum = chan_sq(palette_copy[i].r, q.r) + chan_sq(palette_copy[i].g, q.g)
				+ chan_sq(palette_copy[i].b, q.b);
			if (sq_sum < lead_dist) begin
				lead_dist = sq_sum;
				best.idx  = IDX_W'(i);
			end
		end
		best.dist_val = lead_dist[DIST_W-1:0];
		return best;
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// Watch both channels at each edge: result beat first, then command beat
	always @(posedge clk or negedge arst_n) begin : beat_watch
		match_t want;
		if (!arst_n) begin
			foreach (palette_copy[i])
				palette_copy[i] = '0;
			nearest_due.delete();
		end else begin
			if (done === 1'b1) begin
				if (nearest_due.size() == 0) begin
					report_mismatch($sformatf("result with no open query: index %0d distance %0d",
						best_index, best_distance));
				end else begin
					want = nearest_due.pop_front();
					if (best_index !== want.idx)
						report_mismatch($sformatf("best_index %0d, predicted %0d",
							best_index, want.idx));
					if (best_distance !== want.dist_val)
						report_mismatch($sformatf("best_distance %0d, predicted %0d",
							best_distance, want.dist_val));
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				if (func == FUNC_WRITE) begin
					// writes past the palette depth are dropped
					if (entry_index < PALETTE_ENTRIES)
						palette_copy[entry_index] = '{r: red, g: green, b: blue};
				end else begin
					nearest_due.push_back(find_nearest('{r: red, g: green, b: blue}));
				end
			end
		end
		fail_count <= errors;
		pending    <= nearest_due.size();
	end

endmodule : nearest_palette_color_search_checker

// ===== tb/nearest_palette_color_search_top_tb.sv =====
// Testbench top for the nearest palette color search block: drives palette writes and queries,
// directed then random, and gives the verdict. Depends on npcs_pkg, the top and the checker file.
`timescale 1ns / 1ps

module nearest_palette_color_search_top_tb
	import npcs_pkg::*;
	import npcs_tb_pkg::*;
();

	localparam int unsigned ENTRIES = PALETTE_ENTRIES_DEF;
	localparam int ITEM_COUNT   = 1600;
	localparam int CALM_TAIL    = 200;           // last items go without idling
	localparam int STALL_LIMIT  = 4000;          // cycles with no beat on either side
	localparam int DRAIN_CYCLES = ENTRIES + 16;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              func;
	logic [IDX_W-1:0]  entry_index;
	logic [CH_W-1:0]   red;
	logic [CH_W-1:0]   green;
	logic [CH_W-1:0]   blue;
	logic              done;
	logic [IDX_W-1:0]  best_index;
	logic [DIST_W-1:0] best_distance;
	int                fail_count;
	int                pending;
	int                idle_cycles = 0;
	rgb_t              written [256];   // colors loaded so far, used to aim queries

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	nearest_palette_color_search_top #(.PALETTE_ENTRIES(ENTRIES)) dut (.*);

	nearest_palette_color_search_checker #(.PALETTE_ENTRIES(ENTRIES)) checker_i (.*);

	// Watchdog: count cycles in which neither a command nor a result beat moves
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Present one command and hold it until the edge that takes it
	task automatic send_beat(input func_e f, input logic [IDX_W-1:0] idx, input rgb_t c);
		start       <= 1'b1;
		func        <= f;
		entry_index <= idx;
		red         <= c.r;
		green       <= c.g;
		blue        <= c.b;
		do
			@(posedge clk);
		while (busy !== 1'b0);
	endtask

	task automatic load_entry(input logic [IDX_W-1:0] idx, input rgb_t c);
		written[idx] = c;
		send_beat(FUNC_WRITE, idx, c);
	endtask

	// entry_index is don't-care for queries, so it gets noise
	task automatic ask_nearest(input rgb_t c);
		send_beat(FUNC_QUERY, IDX_W'($urandom), c);
	endtask

	// Drop start for a burst; optionally let a running query finish first
	task automatic hold_off(input int cycles, input bit past_busy);
		start <= 1'b0;
		@(posedge clk);
		if (past_busy)
			while (busy !== 1'b0)
				@(posedge clk);
		repeat (cycles - 1)
			@(posedge clk);
	endtask

	function automatic logic [CH_W-1:0] random_channel();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return CH_W'($urandom);
		endcase
	endfunction

	function automatic rgb_t random_color();
		rgb_t c;
		c.r = random_channel();
		c.g = random_channel();
		c.b = random_channel();
		return c;
	endfunction

	// Move a channel by up to 3 steps, clamped to the channel range
	function automatic logic [CH_W-1:0] nudge(logic [CH_W-1:0] ch);
		int v;
		v = int'(ch) + int'($urandom_range(0, 6)) - 3;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return CH_W'(v);
	endfunction

	initial begin
		rgb_t c;
		int   kind;
		start       <= 1'b0;
		func        <= FUNC_WRITE;
		entry_index <= '0;
		red         <= '0;
		green       <= '0;
		blue        <= '0;
		arst_n      <= 1'b0;
		foreach (written[i])
			written[i] = '0;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: all-black palette, exact hits, ties, extremes of both ends
		ask_nearest(rgb_t'(24'h000000));         // exact hit at entry 0
		ask_nearest(rgb_t'(24'hFFFFFF));         // every entry equally far, max distance
		load_entry(8'd255, rgb_t'(24'hFFFFFF));
		ask_nearest(rgb_t'(24'hFFFFFF));         // match only in the last entry
		load_entry(8'd0, rgb_t'(24'hFF0000));
		ask_nearest(rgb_t'(24'h000000));         // first black entry is now 1
		ask_nearest(rgb_t'(24'hFE0101));
		load_entry(8'd10, rgb_t'(24'h646464));
		load_entry(8'd20, rgb_t'(24'h646464));
		ask_nearest(rgb_t'(24'h656464));         // tie between 10 and 20
		ask_nearest(rgb_t'(24'h646464));
		load_entry(8'd128, rgb_t'(24'h00FF00));
		load_entry(8'd129, rgb_t'(24'h0000FF));
		ask_nearest(rgb_t'(24'h00FA05));
		ask_nearest(rgb_t'(24'h0303FA));
		load_entry(8'd200, rgb_t'(24'hFFFFFF));
		ask_nearest(rgb_t'(24'hFFFFFF));         // duplicate of 255 at a lower index
		ask_nearest(rgb_t'(24'h808080));

		// Random: half writes, half queries mostly aimed at loaded colors
		for (int n = 0; n < ITEM_COUNT; n++) begin
			if ($urandom_range(0, 1) == 0) begin
				if ($urandom_range(0, 4) == 0)
					c = written[IDX_W'($urandom)];   // duplicate color, makes ties
				else
					c = random_color();
				load_entry(IDX_W'($urandom), c);
			end else begin
				kind = $urandom_range(0, 9);
				c    = written[IDX_W'($urandom)];
				if (kind >= 7)
					c = random_color();
				else if (kind >= 4)
					c = '{r: nudge(c.r), g: nudge(c.g), b: nudge(c.b)};
				ask_nearest(c);
			end
			if (n < ITEM_COUNT - CALM_TAIL && $urandom_range(0, 5) == 0)
				hold_off(int'($urandom_range(1, 6)), 1'($urandom_range(0, 1)));
		end
		start <= 1'b0;

		// Drain: wait for every open query, then one more scan's worth
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule : nearest_palette_color_search_top_tb

// ===== nearest_palette_color_search_top.f =====
hw/rtl/npcs_pkg.sv
hw/rtl/npcs_cell.sv
hw/rtl/npcs_dist.sv
hw/rtl/nearest_palette_color_search_top.sv
tb/nearest_palette_color_search_checker.sv
tb/nearest_palette_color_search_top_tb.sv
